// ===== hdl/ptc_pkg.sv =====
// Shared types, constants and register indexes for the pressure/temperature compensation pipeline
`default_nettype none
package ptc_pkg;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] REG_TEMP_CAL = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LOW = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LAST = 2'd3;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_BASE = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] ROUND_HALF = 64'd128;

    // Calibration coefficients widened to 64 bits: t1 and p1 zero-extended, the rest sign-extended
    typedef struct packed {
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [63:0] p3;
        logic [63:0] p4;
        logic [63:0] p5;
        logic [63:0] p6;
        logic [63:0] p7;
        logic [63:0] p8;
        logic [63:0] p9;
    } cal_t;

    // Item handed from the front pipeline to the divider
    typedef struct packed {
        logic [63:0] numer;
        logic [63:0] denom;
        logic [15:0] temp;
    } div_req_t;

    // Division result plus the fields that ride along
    typedef struct packed {
        logic [63:0] quot;
        logic        valid;
        logic [15:0] temp;
    } div_rsp_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        asr64 = $unsigned($signed(x) >>> n);
    endfunction

    // 64x64 wrap-around product, built from 32x32 partial products
    function automatic logic [63:0] mul_lo(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
        ll = 64'(a[31:0]) * 64'(b[31:0]);
        lh = 32'(a[31:0] * b[63:32]);
        hl = 32'(a[63:32] * b[31:0]);
        mul_lo = ll + {lh + hl, 32'd0};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ptc_divider.sv =====
// Pipelined 64-bit signed divider, two quotient bits per stage, truncating toward zero
`default_nettype none
module ptc_divider
    import ptc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire logic     in_vld,
    input  wire div_req_t in_req,
    output logic          out_vld,
    output div_rsp_t      out_rsp
);

    localparam int Stages = 32;

    logic [Stages:0]       vld_reg;
    logic [Stages:0][63:0] rem_reg;
    logic [Stages:0][63:0] quo_reg;
    logic [Stages:0][63:0] dvs_reg;
    logic [Stages:0]       neg_reg;
    logic [Stages:0]       nz_reg;
    logic [Stages:0][15:0] tmp_reg;

    logic                  na;
    logic                  nb;

    // Stage zero: take magnitudes
    assign na = in_req.numer[63];
    assign nb = in_req.denom[63];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Stages-1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            quo_reg[0] <= na ? 64'(0) - in_req.numer : in_req.numer;
            dvs_reg[0] <= nb ? 64'(0) - in_req.denom : in_req.denom;
            neg_reg[0] <= na ^ nb;
            nz_reg[0]  <= |in_req.denom;
            tmp_reg[0] <= in_req.temp;
        end
    end

    // Restoring stages: each retires two quotient bits
    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic [64:0] r1;
        logic [64:0] d1;
        logic [63:0] q1;
        logic [64:0] r2;
        logic [64:0] d2;
        logic [63:0] q2;
        always_comb begin
            r1 = {rem_reg[s], quo_reg[s][63]};
            q1 = {quo_reg[s][62:0], 1'b0};
            d1 = r1 - {1'b0, dvs_reg[s]};
            if (!d1[64]) begin
                r1 = d1;
                q1[0] = 1'b1;
            end
            r2 = {r1[63:0], q1[63]};
            q2 = {q1[62:0], 1'b0};
            d2 = r2 - {1'b0, dvs_reg[s]};
            if (!d2[64]) begin
                r2 = d2;
                q2[0] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1] <= r2[63:0];
                quo_reg[s+1] <= q2;
                dvs_reg[s+1] <= dvs_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                nz_reg[s+1]  <= nz_reg[s];
                tmp_reg[s+1] <= tmp_reg[s];
            end
        end
    end

    assign out_vld       = vld_reg[Stages];
    assign out_rsp.quot  = neg_reg[Stages] ? 64'(0) - quo_reg[Stages] : quo_reg[Stages];
    assign out_rsp.valid = nz_reg[Stages];
    assign out_rsp.temp  = tmp_reg[Stages];

endmodule
`default_nettype wire

// ===== hdl/pressure_temperature_compensation.sv =====
// Top level of the pressure/temperature compensation pipeline
//
// Compensates one raw 20-bit temperature and pressure pair per clock unless the output
// stalls: front pipeline (fine-temperature and polynomial terms), pipelined radix-4
// divider, back pipeline (quadratic correction and saturation). The whole pipeline
// advances together when the output register is empty or being drained, so s_axis_tready
// follows m_axis_tready or an empty output slot. The user must write calibration through
// cfg_we/cfg_index/cfg_data only while no beat is in flight; the block does not check.
`default_nettype none
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // raw_temperature [19:0], raw_pressure [39:20]
    input  wire logic [39:0]         s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // temperature_centi [15:0], pressure_q8 [47:16], pressure_valid [48], zero pad [55:49]
    output logic [55:0]              m_axis_tdata
);

    localparam int FrontStages = 8;
    localparam int BackStages = 6;

    logic [47:0] tcal_reg;
    logic [63:0] plow_reg;
    logic [63:0] phigh_reg;
    logic [15:0] plast_reg;
    cal_t        cal;

    logic        en;
    logic        out_vld_reg;
    logic [55:0] out_data_reg;

    // Hold calibration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcal_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            plast_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TEMP_CAL:   tcal_reg  <= cfg_data[47:0];
                REG_PRESS_LOW:  plow_reg  <= cfg_data;
                REG_PRESS_HIGH: phigh_reg <= cfg_data;
                REG_PRESS_LAST: plast_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1 = {48'd0, tcal_reg[15:0]};
        cal.t2 = sx16(tcal_reg[31:16]);
        cal.t3 = sx16(tcal_reg[47:32]);
        cal.p1 = {48'd0, plow_reg[15:0]};
        cal.p2 = sx16(plow_reg[31:16]);
        cal.p3 = sx16(plow_reg[47:32]);
        cal.p4 = sx16(plow_reg[63:48]);
        cal.p5 = sx16(phigh_reg[15:0]);
        cal.p6 = sx16(phigh_reg[31:16]);
        cal.p7 = sx16(phigh_reg[47:32]);
        cal.p8 = sx16(phigh_reg[63:48]);
        cal.p9 = sx16(plast_reg);
    end

    // Advance whole pipeline when the output slot frees
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- Front pipeline ----------------
    logic [FrontStages-1:0] fv_reg;
    logic [63:0] f1_x_reg, f1_d_reg, f1_p_reg;
    logic [63:0] f2_ax_reg, f2_dd_reg, f2_p_reg;
    logic [63:0] f3_a_reg, f3_b_reg, f3_p_reg;
    logic [63:0] f4_fine_reg, f4_p_reg;
    logic [63:0] f5_a_reg, f5_t5_reg, f5_p_reg;
    logic [15:0] f6_temp_reg;
    logic [63:0] f6_aa_reg, f6_a5_reg, f6_a2_reg, f6_p_reg;
    logic [15:0] f7_temp_reg;
    logic [63:0] f7_b1_reg, f7_b2_reg, f7_a3_reg, f7_a2_reg, f7_p_reg;
    logic [15:0] f8_temp_reg;
    logic [63:0] f8_b_reg, f8_a_reg, f8_p_reg;
    logic [63:0] t_round;
    logic [15:0] t_sat;
    div_req_t    dreq;

    always_comb begin
        t_round = asr64(f5_t5_reg + ROUND_HALF, 8);
        if (t_round[63] && $signed(t_round) < -64'sd32768) begin
            t_sat = 16'h8000;
        end else if (!t_round[63] && t_round > 64'd32767) begin
            t_sat = 16'h7FFF;
        end else begin
            t_sat = t_round[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[FrontStages-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // S1: differences
            f1_x_reg <= 64'(s_axis_tdata[19:3]) - (cal.t1 << 1);
            f1_d_reg <= 64'(s_axis_tdata[19:4]) - cal.t1;
            f1_p_reg <= PRESS_BASE - 64'(s_axis_tdata[39:20]);
            // S2: products
            f2_ax_reg <= mul_lo(f1_x_reg, cal.t2);
            f2_dd_reg <= mul_lo(f1_d_reg, f1_d_reg);
            f2_p_reg  <= f1_p_reg;
            // S3
            f3_a_reg <= asr64(f2_ax_reg, 11);
            f3_b_reg <= mul_lo(asr64(f2_dd_reg, 12), cal.t3);
            f3_p_reg <= f2_p_reg;
            // S4: fine temperature
            f4_fine_reg <= f3_a_reg + asr64(f3_b_reg, 14);
            f4_p_reg    <= f3_p_reg;
            // S5
            f5_a_reg  <= f4_fine_reg - FINE_OFFSET;
            f5_t5_reg <= f4_fine_reg * 64'd5;
            f5_p_reg  <= f4_p_reg;
            // S6
            f6_temp_reg <= t_sat;
            f6_aa_reg   <= mul_lo(f5_a_reg, f5_a_reg);
            f6_a5_reg   <= mul_lo(f5_a_reg, cal.p5);
            f6_a2_reg   <= mul_lo(f5_a_reg, cal.p2);
            f6_p_reg    <= f5_p_reg;
            // S7
            f7_temp_reg <= f6_temp_reg;
            f7_b1_reg   <= mul_lo(f6_aa_reg, cal.p6);
            f7_b2_reg   <= (f6_a5_reg << 17) + (cal.p4 << 35);
            f7_a3_reg   <= mul_lo(f6_aa_reg, cal.p3);
            f7_a2_reg   <= f6_a2_reg << 12;
            f7_p_reg    <= f6_p_reg;
            // S8
            f8_temp_reg <= f7_temp_reg;
            f8_b_reg    <= f7_b1_reg + f7_b2_reg;
            f8_a_reg    <= (64'd1 << 47) + asr64(f7_a3_reg, 8) + f7_a2_reg;
            f8_p_reg    <= f7_p_reg << 31;
        end
    end

    // S9 prep: numerator and divisor (registered in divider stage zero)
    logic [63:0] num_diff;
    assign num_diff   = f8_p_reg - f8_b_reg;
    assign dreq.numer = mul_lo(num_diff, PRESS_SCALE);
    assign dreq.denom = asr64(mul_lo(f8_a_reg, cal.p1), 33);
    assign dreq.temp  = f8_temp_reg;

    logic     dv;
    div_rsp_t drsp;

    ptc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (fv_reg[FrontStages-1]),
        .in_req  (dreq),
        .out_vld (dv),
        .out_rsp (drsp)
    );

    // ---------------- Back pipeline ----------------
    logic [BackStages-2:0] bv_reg;
    logic [63:0] b1_p_reg, b1_d_reg;
    logic        b1_ok_reg;
    logic [15:0] b1_t_reg;
    logic [63:0] b2_p_reg, b2_dd_reg, b2_c2_reg;
    logic        b2_ok_reg;
    logic [15:0] b2_t_reg;
    logic [63:0] b3_p_reg, b3_c1_reg, b3_c2_reg;
    logic        b3_ok_reg;
    logic [15:0] b3_t_reg;
    logic [63:0] b4_s_reg;
    logic        b4_ok_reg;
    logic [15:0] b4_t_reg;
    logic [63:0] b5_p_reg;
    logic        b5_ok_reg;
    logic [15:0] b5_t_reg;
    logic [31:0] p_sat;

    always_comb begin
        if (!b5_ok_reg || b5_p_reg[63]) begin
            p_sat = '0;
        end else if (|b5_p_reg[63:32]) begin
            p_sat = '1;
        end else begin
            p_sat = b5_p_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (en) begin
            bv_reg <= {bv_reg[BackStages-3:0], dv};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_p_reg  <= drsp.quot;
            b1_d_reg  <= asr64(drsp.quot, 13);
            b1_ok_reg <= drsp.valid;
            b1_t_reg  <= drsp.temp;
            b2_p_reg  <= b1_p_reg;
            b2_dd_reg <= mul_lo(cal.p9, b1_d_reg);
            b2_c2_reg <= asr64(mul_lo(cal.p8, b1_p_reg), 19);
            b2_ok_reg <= b1_ok_reg;
            b2_t_reg  <= b1_t_reg;
            b3_p_reg  <= b2_p_reg;
            b3_c1_reg <= mul_lo(b2_dd_reg, asr64(b2_p_reg, 13));
            b3_c2_reg <= b2_c2_reg;
            b3_ok_reg <= b2_ok_reg;
            b3_t_reg  <= b2_t_reg;
            b4_s_reg  <= b3_p_reg + asr64(b3_c1_reg, 25) + b3_c2_reg;
            b4_ok_reg <= b3_ok_reg;
            b4_t_reg  <= b3_t_reg;
            b5_p_reg  <= asr64(b4_s_reg, 8) + (cal.p7 << 4);
            b5_ok_reg <= b4_ok_reg;
            b5_t_reg  <= b4_t_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= bv_reg[BackStages-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {7'd0, b5_ok_reg, p_sat, b5_t_reg};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output slot");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[47:16] == 32'd0)
        else $error("invalid pressure not zero");
`endif

endmodule
`default_nettype wire

// ===== tb/pressure_temperature_compensation_tb.sv =====
// Self-checking testbench for the pressure/temperature compensation pipeline
`default_nettype none
module pressure_temperature_compensation_tb;
    import ptc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 47;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic        valid;
        logic [31:0] press;
        logic [15:0] temp;
    } comp_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [55:0]         m_axis_tdata;

    // shadow calibration used by the predictor
    logic [47:0] cal_temp = '0;
    logic [63:0] cal_plow = '0;
    logic [63:0] cal_phigh = '0;
    logic [15:0] cal_p9 = '0;

    comp_t  expected_q[$];
    int     mismatches = 0;
    int     beats_in = 0;
    int     beats_out = 0;
    int     invalid_seen = 0;
    int     hold_off = 0;
    int     rx_wait = 0;
    bit     rx_gaps = 1'b1;
    longint cycles = 0;

    pressure_temperature_compensation i_dut (.*);

    always #5 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sra(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    // Compute the compensated temperature and pressure for one raw pair
    function automatic comp_t compensate(input logic [19:0] rt, input logic [19:0] rp);
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, b, d, fine, t, p, c1, c2, ua, ub, q;
        comp_t r;
        t1 = {48'd0, cal_temp[15:0]};
        t2 = sext16(cal_temp[31:16]);
        t3 = sext16(cal_temp[47:32]);
        p1 = {48'd0, cal_plow[15:0]};
        p2 = sext16(cal_plow[31:16]);
        p3 = sext16(cal_plow[47:32]);
        p4 = sext16(cal_plow[63:48]);
        p5 = sext16(cal_phigh[15:0]);
        p6 = sext16(cal_phigh[31:16]);
        p7 = sext16(cal_phigh[47:32]);
        p8 = sext16(cal_phigh[63:48]);
        p9 = sext16(cal_p9);
        a = sra(((64'(rt) >> 3) - (t1 << 1)) * t2, 11);
        d = (64'(rt) >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        t = sra(fine * 64'd5 + 64'd128, 8);
        if ($signed(t) < -32768) r.temp = 16'h8000;
        else if ($signed(t) > 32767) r.temp = 16'h7fff;
        else r.temp = t[15:0];
        a = fine - 64'd128000;
        b = a * a * p6;
        b = b + ((a * p5) << 17);
        b = b + (p4 << 35);
        a = sra(a * a * p3, 8) + ((a * p2) << 12);
        a = sra(((64'd1 << 47) + a) * p1, 33);
        if (a == 0) begin
            r.press = '0;
            r.valid = 1'b0;
        end else begin
            p = 64'd1048576 - 64'(rp);
            p = ((p << 31) - b) * 64'd3125;
            ua = p[63] ? -p : p;
            ub = a[63] ? -a : a;
            q = ua / ub;
            p = (p[63] != a[63]) ? -q : q;
            d = sra(p, 13);
            c1 = sra(p9 * d * d, 25);
            c2 = sra(p8 * p, 19);
            p = sra(p + c1 + c2, 8) + (p7 << 4);
            if (p[63]) r.press = '0;
            else if (p > 64'hffff_ffff) r.press = 32'hffff_ffff;
            else r.press = p[31:0];
            r.valid = 1'b1;
        end
        return r;
    endfunction

    // Receiver: a random wait after each beat while rx_gaps is set, plus an optional long hold-off
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tready && m_axis_tvalid && rx_gaps) begin
            w = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
            m_axis_tready <= (w == 0);
            rx_wait <= (w > 0) ? w - 1 : 0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge aclk) begin
        comp_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[48:0];
            beats_out <= beats_out + 1;
            if (!got.valid) invalid_seen <= invalid_seen + 1;
            if (expected_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                if (got !== want || m_axis_tdata[55:49] !== '0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp temp %0d press %h valid %b, got %0d %h %b",
                                 $signed(want.temp), want.press, want.valid,
                                 $signed(got.temp), got.press, got.valid);
                end
            end
        end
    end

    // Send one raw pair, with an optional leading gap; valid stays up for a following beat
    task automatic send_pair(input logic [19:0] rt, input logic [19:0] rp, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rp, rt};
        expected_q.push_back(compensate(rt, rp));
        do @(posedge aclk); while (!s_axis_tready);
        beats_in++;
    endtask

    task automatic send_random(input int n, input bit gaps);
        repeat (n) send_pair(20'($urandom), 20'($urandom),
                             gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0) : 0);
    endtask

    // Drop valid, wait until every result is in, then let the pipeline drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_TEMP_CAL:   cal_temp = val[47:0];
            REG_PRESS_LOW:  cal_plow = val;
            REG_PRESS_HIGH: cal_phigh = val;
            REG_PRESS_LAST: cal_p9 = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [47:0] tc, input logic [63:0] pl,
                            input logic [63:0] ph, input logic [15:0] p9);
        write_reg(REG_TEMP_CAL, {16'd0, tc});
        write_reg(REG_PRESS_LOW, pl);
        write_reg(REG_PRESS_HIGH, ph);
        write_reg(REG_PRESS_LAST, {48'd0, p9});
        cfg_we <= 1'b0;
    endtask

    // Typical sensor calibration set
    task automatic load_typical();
        load_cal({16'hfc18, 16'h6725, 16'd27504},
                 {16'd2855, 16'h0bd0, 16'hd870, 16'd36477},
                 {16'h3c3c, 16'd15500, 16'hfff9, 16'h008c}, 16'd6000);
    endtask

    // Zero calibration forces the divisor to zero
    task automatic test_zero_divisor();
        send_pair(20'd0, 20'd0, 0);
        send_pair(20'hfffff, 20'hfffff, 3);
        send_pair(20'h80000, 20'h55555, 0);
        drain();
    endtask

    // Field extremes and typical readings under a real calibration
    task automatic test_directed();
        load_typical();
        send_pair(20'd0, 20'd0, 0);
        send_pair(20'hfffff, 20'hfffff, 0);
        send_pair(20'd0, 20'hfffff, 1);
        send_pair(20'hfffff, 20'd0, 0);
        send_pair(20'd519888, 20'd415148, 0);
        send_pair(20'h7ffff, 20'h80000, 2);
        send_pair(20'haaaaa, 20'h55555, 0);
        drain();
    endtask

    // Extreme calibrations: saturation, negative pressure, wraparound
    task automatic test_extreme_cal();
        load_cal({16'h7fff, 16'h7fff, 16'hffff}, '1, '0, 16'h7fff);
        send_random(6, 0);
        send_pair(20'hfffff, 20'd0, 0);
        drain();
        load_cal({16'h8000, 16'h8000, 16'd0}, 64'h8000_8000_8000_0001,
                 64'h8000_8000_8000_8000, 16'h8000);
        send_random(6, 0);
        send_pair(20'd0, 20'hfffff, 0);
        drain();
        load_cal({16'h7fff, 16'h8000, 16'h0001}, 64'h7fff_7fff_7fff_ffff,
                 64'h7fff_7fff_7fff_7fff, 16'h7fff);
        send_random(6, 0);
        drain();
    endtask

    // Long receiver hold-off fills the pipeline, then sender waits for drain; a second run has no receiver gaps
    task automatic test_backpressure();
        load_typical();
        hold_off = 300;
        send_random(120, 0);
        drain();
        rx_gaps = 1'b0;
        send_random(100, 0);
        drain();
        rx_gaps = 1'b1;
    endtask

    // Random traffic across several calibration sets
    task automatic test_random();
        for (int s = 0; s < 10; s++) begin
            if (s % 3 == 0) load_typical();
            else load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 16'($urandom));
            send_random(130, 1);
            drain();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_divisor();
        test_directed();
        test_extreme_cal();
        test_backpressure();
        test_random();
        $display("covered %0d input beats, %0d results (%0d with divisor zero)",
                 beats_in, beats_out, invalid_seen);
        $display("calibration extremes, long output stall and random gaps exercised");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== pressure_temperature_compensation.f =====
hdl/ptc_pkg.sv
hdl/ptc_divider.sv
hdl/pressure_temperature_compensation.sv
tb/pressure_temperature_compensation_tb.sv
